@@ rtl/capsup_pkg.sv @@
// Package for the capacitor charge supervisor: machine modes, command codes,
// error codes, register indexes and fixed thresholds.
// No dependencies.
package capsup_pkg;

  typedef enum logic [2:0] {
    MODE_STANDBY     = 3'd0,
    MODE_CHARGING    = 3'd1,
    MODE_CHARGED     = 3'd2,
    MODE_DISCHARGING = 3'd3,
    MODE_SHOCKING    = 3'd4,
    MODE_AFTER_SHOCK = 3'd5,
    MODE_ERROR       = 3'd6,
    MODE_OUT_OF_SVC  = 3'd7
  } mode_t;

  localparam logic [2:0] OP_MONITOR = 3'd0;
  localparam logic [2:0] OP_CHARGE  = 3'd1;
  localparam logic [2:0] OP_DISARM  = 3'd2;
  localparam logic [2:0] OP_OOS     = 3'd3;
  localparam logic [2:0] OP_SHOCK   = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FAST  = 2'd1;
  localparam logic [1:0] ERR_SLOW  = 2'd2;
  localparam logic [1:0] ERR_SHOCK = 2'd3;

  localparam logic [1:0] REG_MAX_VOLTAGE = 2'd0;
  localparam logic [1:0] REG_MAX_CURRENT = 2'd1;
  localparam logic [1:0] REG_PRECHARGE   = 2'd2;
  localparam logic [1:0] REG_DISCH_TEST  = 2'd3;

  localparam logic [10:0] RST_MAX_VOLTAGE = 11'd1400;
  localparam logic [12:0] RST_MAX_CURRENT = 13'd5000;
  localparam logic [10:0] RST_PRECHARGE   = 11'd200;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 48;

endpackage

@@ rtl/capacitor_charge_supervisor.sv @@
// Capacitor charge supervisor: mode machine for a high-voltage capacitor.
// Depends on capsup_pkg for mode, command, error and register codes.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: opcode; tdata: vc_now, target_voltage,
//                       charge_current, temperature, battery_percent,
//                       shock_start_v, shock_mid_v
//  m_axis    out        tdata: machine_state, error_code, voltage_setpoint,
//                       current_limit, discharge_via_relay, reported_vc
//  cfg       in         cfg_wr_en, cfg_addr, cfg_wdata; write only
//
// Every accepted word is captured, then makes four passes through the single
// shared signed multiplier that forms the ramp and ninety-percent products,
// and is then applied in the update stage, which also loads the result.
// The input side is not ready while a word is in progress. The result sits
// in an output register; when it has not been taken yet the update stage
// waits for it. Reset is synchronous and restores the register defaults
// and a standby machine with all counters cleared.
module capacitor_charge_supervisor
  import capsup_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // From bit 0: vc_now[10:0], target_voltage[21:11], charge_current[37:22],
  // temperature[45:38], battery_percent[52:46], shock_start_v[63:53],
  // shock_mid_v[74:64], zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode.
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0: machine_state[2:0], error_code[4:3], voltage_setpoint[15:5],
  // current_limit[28:16], discharge_via_relay[29], reported_vc[40:30], zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_addr,
  input  logic [12:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_EXEC
  } seq_t;

  seq_t state;

  // Configuration registers.
  logic [10:0] max_voltage;
  logic [12:0] max_current;
  logic [10:0] precharge;
  logic        disch_test;

  // Machine state.
  mode_t       mode;
  logic [1:0]  fault;
  logic [10:0] setpoint;
  logic [10:0] checkpoint;
  logic [15:0] tick_count;
  logic [3:0]  tick_mod10;  // tick_count modulo ten, tracked alongside it
  logic [2:0]  slow_count;
  logic [6:0]  timeout_count;
  logic [4:0]  ramp_thr;

  // Captured word.
  logic [2:0]  op;
  logic [10:0] vc, tv, ps, pm;
  logic [15:0] cur;
  logic signed [7:0] temp;
  logic [6:0]  batt;

  // Shared multiplier and its product registers.
  logic signed [16:0] mul_a;
  logic signed [12:0] mul_b;
  logic signed [29:0] mul_p;
  logic signed [29:0] p_tick, p_inc, p_sp, p_vc;

  logic [15:0] tick_inc;
  logic [3:0]  mod_inc;
  logic signed [11:0] inc;

  assign tick_inc = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign mod_inc  = (tick_count == 16'hFFFF) ? tick_mod10 :
                    ((tick_mod10 == 4'd9) ? 4'd0 : tick_mod10 + 4'd1);
  assign inc      = $signed({1'b0, vc}) - $signed({1'b0, checkpoint});

  always_comb begin
    unique case (state)
      ST_MUL0: begin
        mul_a = $signed({1'b0, tick_inc});
        mul_b = 13'sd2001;
      end
      ST_MUL1: begin
        mul_a = 17'(inc);
        mul_b = 13'sd50;
      end
      ST_MUL2: begin
        mul_a = $signed({6'd0, setpoint});
        mul_b = 13'sd90;
      end
      default: begin
        mul_a = $signed({6'd0, vc});
        mul_b = 13'sd100;
      end
    endcase
  end

  assign mul_p = 30'(mul_a) * 30'(mul_b);

  // Update logic, applied in the last cycle of a word.
  mode_t       md_n;
  logic [1:0]  fc_n;
  logic [10:0] sp_n, cp_n, clamp_v;
  logic [15:0] tc_n;
  logic [3:0]  mod_n;
  logic [2:0]  sf_n;
  logic [6:0]  to_n;
  logic [4:0]  rt_n;
  logic [12:0] climit, lim;
  logic        relay;
  logic        fast_hit, near_sp;

  function automatic logic is_inactive(input mode_t m);
    return (m == MODE_ERROR) || (m == MODE_OUT_OF_SVC);
  endfunction

  always_comb begin
    md_n = mode; fc_n = fault; sp_n = setpoint; cp_n = checkpoint;
    tc_n = tick_count; mod_n = tick_mod10; sf_n = slow_count;
    to_n = timeout_count; rt_n = ramp_thr;
    climit = '0; relay = 1'b0; lim = 13'd1000; clamp_v = tv;
    // inc*50/ticks > 2000 exactly when inc*50 >= 2001*ticks (ticks >= 1).
    fast_hit = (p_inc >= p_tick);
    // vc > setpoint*90/100 exactly when setpoint*90 < vc*100.
    near_sp  = (p_sp < p_vc);

    unique case (op)
      OP_MONITOR: begin
        if (mode == MODE_CHARGING) begin
          tc_n  = tick_inc;
          mod_n = mod_inc;
          if (vc >= setpoint) begin
            sf_n = '0; to_n = '0;
            md_n = MODE_CHARGED;
            if (fast_hit) begin
              md_n = MODE_ERROR; fc_n = ERR_FAST;
            end
          end else begin
            if (mod_inc == 4'd0) begin
              cp_n = vc;
              if (to_n < 7'd127) to_n = to_n + 7'd1;
              if (inc < $signed({7'd0, ramp_thr}) && vc < 11'd1300) begin
                if (sf_n < 3'd7) sf_n = sf_n + 3'd1;
              end else begin
                sf_n = '0;
              end
              if (inc > 12'sd400) begin
                md_n = MODE_ERROR; fc_n = ERR_FAST;
              end
            end
            if (sf_n >= 3'd5 && near_sp) begin
              sf_n = '0; to_n = '0;
              if (!is_inactive(md_n)) md_n = MODE_CHARGED;
            end
            if (sf_n >= 3'd5 || to_n >= 7'd125) begin
              md_n = MODE_ERROR; fc_n = ERR_SLOW;
            end
          end
        end
        if (md_n == MODE_DISCHARGING) begin
          sf_n = '0; to_n = '0;
          if (vc < (precharge >> 1)) md_n = MODE_STANDBY;
          else if (vc <= sp_n) md_n = MODE_CHARGED;
        end
        if (is_inactive(md_n)) begin
          sp_n = '0; sf_n = '0; to_n = '0;
        end
      end
      OP_CHARGE: begin
        if (!is_inactive(mode)) begin
          if (vc < tv && (tv - vc) > 11'd5) begin
            rt_n = 5'd9;
            if (temp >= 8'sd5)  begin lim = 13'd2000; rt_n = 5'd12; end
            if (temp >= 8'sd12) begin lim = 13'd3000; rt_n = 5'd15; end
            if (temp >= 8'sd19) begin lim = 13'd4000; rt_n = 5'd18; end
            if (temp >= 8'sd25) begin lim = max_current; rt_n = 5'd20; end
            if (batt < 7'd15) rt_n = 5'd5;
            if (tv > max_voltage) clamp_v = max_voltage;
            climit = (cur > {3'd0, lim}) ? lim : cur[12:0];
            sp_n = clamp_v; md_n = MODE_CHARGING; cp_n = vc;
            tc_n = '0; mod_n = '0;
          end
          if (vc > tv) begin
            if (disch_test) begin
              sp_n = '0; md_n = MODE_DISCHARGING; relay = 1'b1;
            end else if ((vc - tv) > 11'd5) begin
              relay = (tv <= 11'd10) && (vc < 11'd400);
              sp_n  = (tv <= 11'd10) ? 11'd0 : tv;
              md_n  = MODE_DISCHARGING;
            end
          end
        end
      end
      OP_DISARM: begin
        sp_n = '0; relay = 1'b1;
        if (!is_inactive(mode)) md_n = MODE_DISCHARGING;
      end
      OP_OOS: begin
        if (mode == MODE_STANDBY || mode == MODE_CHARGED || mode == MODE_AFTER_SHOCK)
          md_n = MODE_OUT_OF_SVC;
      end
      OP_SHOCK: begin
        if (!is_inactive(mode)) begin
          if (ps > pm && (ps - pm) >= 11'd100 && pm > vc && (pm - vc) >= 11'd100) begin
            md_n = MODE_AFTER_SHOCK;
          end else begin
            md_n = MODE_ERROR; fc_n = ERR_SHOCK;
          end
        end
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      max_voltage <= RST_MAX_VOLTAGE;
      max_current <= RST_MAX_CURRENT;
      precharge <= RST_PRECHARGE;
      disch_test <= 1'b0;
      mode <= MODE_STANDBY;
      fault <= ERR_NONE;
      setpoint <= '0;
      checkpoint <= '0;
      tick_count <= '0;
      tick_mod10 <= '0;
      slow_count <= '0;
      timeout_count <= '0;
      ramp_thr <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MAX_VOLTAGE: max_voltage <= cfg_wdata[10:0];
          REG_MAX_CURRENT: max_current <= cfg_wdata;
          REG_PRECHARGE:   precharge <= cfg_wdata[10:0];
          REG_DISCH_TEST:  disch_test <= cfg_wdata[0];
          default: ;
        endcase
      end
      // In the update cycle a taken result is replaced by the new one below.
      if (m_tvalid && m_tready && state != ST_EXEC) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op   <= s_tuser;
            vc   <= s_tdata[10:0];
            tv   <= s_tdata[21:11];
            cur  <= s_tdata[37:22];
            temp <= $signed(s_tdata[45:38]);
            batt <= s_tdata[52:46];
            ps   <= s_tdata[63:53];
            pm   <= s_tdata[74:64];
            state <= ST_MUL0;
          end
        end
        ST_MUL0: begin p_tick <= mul_p; state <= ST_MUL1; end
        ST_MUL1: begin p_inc  <= mul_p; state <= ST_MUL2; end
        ST_MUL2: begin p_sp   <= mul_p; state <= ST_MUL3; end
        ST_MUL3: begin p_vc   <= mul_p; state <= ST_EXEC; end
        ST_EXEC: begin
          if (!m_tvalid || m_tready) begin
            mode <= md_n; fault <= fc_n; setpoint <= sp_n; checkpoint <= cp_n;
            tick_count <= tc_n; tick_mod10 <= mod_n; slow_count <= sf_n;
            timeout_count <= to_n; ramp_thr <= rt_n;
            m_tdata <= {7'd0, (vc < 11'd10) ? 11'd0 : vc, relay, climit,
                        sp_n, fc_n, md_n};
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
